@@ src/ntes_pkg.sv @@
package ntes_pkg;

  // Depth of each flicker pattern store.
  localparam int unsigned PATTERN_DEPTH = 64;

  // Tube states, as reported on the tube_state output.
  localparam logic [3:0] ST_OFF     = 4'd0;
  localparam logic [3:0] ST_START   = 4'd1;
  localparam logic [3:0] ST_SP_EVEN = 4'd2;
  localparam logic [3:0] ST_SP_ODD  = 4'd3;
  localparam logic [3:0] ST_GLOW    = 4'd4;
  localparam logic [3:0] ST_FAIL    = 4'd5;
  localparam logic [3:0] ST_RP_EVEN = 4'd6;
  localparam logic [3:0] ST_RP_ODD  = 4'd7;
  localparam logic [3:0] ST_END     = 4'd8;

  // Item function codes.
  localparam logic [2:0] FUNC_TICK          = 3'd0;
  localparam logic [2:0] FUNC_SWITCH_ON     = 3'd1;
  localparam logic [2:0] FUNC_SWITCH_OFF    = 3'd2;
  localparam logic [2:0] FUNC_WRITE_START   = 3'd3;
  localparam logic [2:0] FUNC_WRITE_RESTART = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_FAILURE_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_FAILURE_DURATION  = 3'd1;
  localparam logic [2:0] REG_START_DELAY       = 3'd2;
  localparam logic [2:0] REG_END_DELAY         = 3'd3;
  localparam logic [2:0] REG_START_PERIOD      = 3'd4;
  localparam logic [2:0] REG_RESTART_PERIOD    = 3'd5;
  localparam logic [2:0] REG_START_SETUP       = 3'd6;
  localparam logic [2:0] REG_RESTART_SETUP     = 3'd7;

  localparam logic [15:0] STEP_PERIOD_RESET = 16'd10;

  typedef struct packed {
    logic       write;
    logic       pwm;
    logic [7:0] level;
    logic [3:0] state;
  } result_t;

endpackage

@@ src/ntes_pattern_mem.sv @@
module ntes_pattern_mem import ntes_pkg::*; #(
  parameter int unsigned Depth = 64
) (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [5:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic [6:0] raddr_i,
  output logic [7:0] rdata_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]       mem [Depth];
  logic [7:0]       rdata_q;
  logic             rd_ok_q;
  logic             wr_ok;
  logic             rd_ok;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;

  assign wr_ok = ({3'b000, waddr_i} < 9'(Depth));
  assign rd_ok = ({2'b00, raddr_i} < 9'(Depth));
  assign waddr = AddrW'(waddr_i);
  assign raddr = AddrW'(raddr_i);

  // Write-first: a write to the address being read is seen on the next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i && wr_ok) begin
      mem[waddr] <= wdata_i;
    end
    if (we_i && wr_ok && rd_ok && (waddr == raddr)) begin
      rdata_q <= wdata_i;
    end else if (rd_ok) begin
      rdata_q <= mem[raddr];
    end else begin
      rdata_q <= 8'd0;
    end
    rd_ok_q <= rd_ok;
  end

  assign rdata_o = rd_ok_q ? rdata_q : 8'd0;

endmodule

@@ src/neon_tube_effect_sequencer.sv @@
// Neon tube effect sequencer.
// Items arrive on the input channel (in_valid_i / in_stall_o); one result
// transaction leaves on the output channel (out_valid_o / out_stall_i) for
// every accepted item. A tick item advances time by one unit: it either
// enters a pending state change, driving the lamp through drive_write_o,
// drive_pwm_o and drive_level_o (not for start or end), or counts down the
// armed one-shot timer. Switch items set the target state and latch base
// delay plus jitter; entry items write the start or restart flicker pattern.
// Each result is registered, in the skid register while the output stalls.
// Throughput is one item per cycle while in_stall_o is low, set by the single
// state update between the input and the result register; the pattern entry
// for the current step is prefetched from its memory, hiding the lookup.
// A two-entry output stage (result register plus skid register) lets one more
// item be taken while a result is stalled; in_stall_o rises only when both are
// full. Configuration writes (cfg_valid_i / cfg_ready_o) are always taken.
// Reset puts the tube in the off state with the timer disarmed and registers
// at their defaults; pattern memories hold garbage until written.
module neon_tube_effect_sequencer import ntes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] jitter_i,
  input  logic [5:0]  entry_index_i,
  input  logic [7:0]  entry_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        drive_write_o,
  output logic        drive_pwm_o,
  output logic [7:0]  drive_level_o,
  output logic [3:0]  tube_state_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  // Configuration registers.
  logic [23:0] fail_int_q, fail_dur_q, start_dly_q, end_dly_q;
  logic [15:0] start_per_q, restart_per_q;
  logic [7:0]  start_setup_q, restart_setup_q;

  // Sequencer state.
  logic [3:0]  target_q, target_d;
  logic [3:0]  cur_q, cur_d;
  logic [6:0]  step_q, step_d;
  logic [24:0] tleft_q, tleft_d;
  logic        armed_q, armed_d;
  logic [24:0] pend_on_q, pend_on_d;
  logic [24:0] pend_off_q, pend_off_d;

  // Output stage.
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;

  logic       in_fire, out_fire;
  logic       we_start, we_restart;
  logic [7:0] start_rdata, restart_rdata;
  logic [7:0] pat_val;
  logic [24:0] tleft_dec;
  logic [6:0]  step_inc;
  logic [6:0]  cur_len;

  function automatic logic [6:0] pat_len(input logic [7:0] setup);
    logic [6:0] n;
    n = setup[6:0];
    return ({2'b00, n} > 9'(PATTERN_DEPTH)) ? 7'(PATTERN_DEPTH) : n;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_int_q      <= '0;
      fail_dur_q      <= '0;
      start_dly_q     <= '0;
      end_dly_q       <= '0;
      start_per_q     <= STEP_PERIOD_RESET;
      restart_per_q   <= STEP_PERIOD_RESET;
      start_setup_q   <= '0;
      restart_setup_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FAILURE_INTERVAL: fail_int_q      <= cfg_data_i;
        REG_FAILURE_DURATION: fail_dur_q      <= cfg_data_i;
        REG_START_DELAY:      start_dly_q     <= cfg_data_i;
        REG_END_DELAY:        end_dly_q       <= cfg_data_i;
        REG_START_PERIOD:     start_per_q     <= cfg_data_i[15:0];
        REG_RESTART_PERIOD:   restart_per_q   <= cfg_data_i[15:0];
        REG_START_SETUP:      start_setup_q   <= cfg_data_i[7:0];
        REG_RESTART_SETUP:    restart_setup_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // An item is taken unless the skid register already holds a result.
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  assign we_start   = in_fire && (func_i == FUNC_WRITE_START);
  assign we_restart = in_fire && (func_i == FUNC_WRITE_RESTART);

  // Both memories are read at the step index of the next cycle, so the entry
  // for the current step is ready when the pattern state is entered.
  ntes_pattern_mem #(.Depth(PATTERN_DEPTH)) u_start_mem (
    .clk_i   (clk_i),
    .we_i    (we_start),
    .waddr_i (entry_index_i),
    .wdata_i (entry_value_i),
    .raddr_i (step_d),
    .rdata_o (start_rdata)
  );

  ntes_pattern_mem #(.Depth(PATTERN_DEPTH)) u_restart_mem (
    .clk_i   (clk_i),
    .we_i    (we_restart),
    .waddr_i (entry_index_i),
    .wdata_i (entry_value_i),
    .raddr_i (step_d),
    .rdata_o (restart_rdata)
  );

  assign tleft_dec = (tleft_q != 25'd0) ? (tleft_q - 25'd1) : 25'd0;
  assign step_inc  = step_q + 7'd1;
  assign cur_len   = ((cur_q == ST_SP_EVEN) || (cur_q == ST_SP_ODD)) ?
                     pat_len(start_setup_q) : pat_len(restart_setup_q);

  always_comb begin
    target_d   = target_q;
    cur_d      = cur_q;
    step_d     = step_q;
    tleft_d    = tleft_q;
    armed_d    = armed_q;
    pend_on_d  = pend_on_q;
    pend_off_d = pend_off_q;
    res        = '0;
    pat_val    = 8'd0;

    if (in_fire) begin
      unique case (func_i)
        FUNC_TICK: begin
          if (target_q != cur_q) begin
            // Enter the pending state.
            cur_d = target_q;
            case (target_q)
              ST_OFF: begin
                armed_d   = 1'b0;
                res.write = 1'b1;
              end
              ST_GLOW: begin
                if (fail_int_q != 24'd0) begin
                  tleft_d = {1'b0, fail_int_q} + {9'd0, jitter_i};
                  armed_d = 1'b1;
                end else begin
                  armed_d = 1'b0;
                end
                res.write = 1'b1;
                res.level = 8'd1;
              end
              ST_FAIL: begin
                tleft_d   = {1'b0, fail_dur_q};
                armed_d   = 1'b1;
                res.write = 1'b1;
              end
              ST_START: begin
                tleft_d = pend_on_q;
                armed_d = 1'b1;
              end
              ST_END: begin
                tleft_d = pend_off_q;
                armed_d = 1'b1;
              end
              ST_SP_EVEN, ST_SP_ODD: begin
                pat_val   = start_rdata;
                res.write = 1'b1;
                res.pwm   = start_setup_q[7];
                res.level = start_setup_q[7] ? pat_val : {7'd0, pat_val != 8'd0};
                tleft_d   = {9'd0, start_per_q};
                armed_d   = 1'b1;
              end
              ST_RP_EVEN, ST_RP_ODD: begin
                pat_val   = restart_rdata;
                res.write = 1'b1;
                res.pwm   = restart_setup_q[7];
                res.level = restart_setup_q[7] ? pat_val : {7'd0, pat_val != 8'd0};
                tleft_d   = {9'd0, restart_per_q};
                armed_d   = 1'b1;
              end
              default: ;
            endcase
          end else if (armed_q) begin
            tleft_d = tleft_dec;
            if (tleft_dec == 25'd0) begin
              // Timer expired: choose the next target.
              armed_d = 1'b0;
              case (cur_q)
                ST_START: begin
                  if (pat_len(start_setup_q) != 7'd0) begin
                    target_d = ST_SP_EVEN;
                    step_d   = 7'd0;
                  end else begin
                    target_d = ST_GLOW;
                  end
                end
                ST_END:  target_d = ST_OFF;
                ST_GLOW: target_d = ST_FAIL;
                ST_FAIL: begin
                  if (pat_len(restart_setup_q) != 7'd0) begin
                    target_d = ST_RP_EVEN;
                    step_d   = 7'd0;
                  end else begin
                    target_d = ST_GLOW;
                  end
                end
                ST_SP_EVEN, ST_SP_ODD, ST_RP_EVEN, ST_RP_ODD: begin
                  step_d = step_inc;
                  if (step_inc >= cur_len) begin
                    target_d = ST_GLOW;
                  end else begin
                    case (cur_q)
                      ST_SP_EVEN: target_d = ST_SP_ODD;
                      ST_SP_ODD:  target_d = ST_SP_EVEN;
                      ST_RP_EVEN: target_d = ST_RP_ODD;
                      default:    target_d = ST_RP_EVEN;
                    endcase
                  end
                end
                default: ;
              endcase
            end
          end
        end
        FUNC_SWITCH_ON: begin
          target_d  = ST_START;
          pend_on_d = {1'b0, start_dly_q} + {9'd0, jitter_i};
        end
        FUNC_SWITCH_OFF: begin
          target_d   = ST_END;
          pend_off_d = {1'b0, end_dly_q} + {9'd0, jitter_i};
        end
        default: ;
      endcase
    end
    res.state = cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= ST_OFF;
      cur_q      <= ST_OFF;
      step_q     <= '0;
      tleft_q    <= '0;
      armed_q    <= 1'b0;
      pend_on_q  <= '0;
      pend_off_q <= '0;
    end else begin
      target_q   <= target_d;
      cur_q      <= cur_d;
      step_q     <= step_d;
      tleft_q    <= tleft_d;
      armed_q    <= armed_d;
      pend_on_q  <= pend_on_d;
      pend_off_q <= pend_off_d;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        out_valid_q  <= skid_valid_q || in_fire;
        skid_valid_q <= 1'b0;
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_write_o = out_q.write;
  assign drive_pwm_o   = out_q.pwm;
  assign drive_level_o = out_q.level;
  assign tube_state_o  = out_q.state;

endmodule
